// File: sv/midi_track_event_encoder_core_assert.svh
// Assertion macros for the encoder checker
`ifndef MIDI_TRACK_EVENT_ENCODER_CORE_ASSERT_SVH
`define MIDI_TRACK_EVENT_ENCODER_CORE_ASSERT_SVH

// checked at every edge, reset included
`define MTE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

// checked only out of reset
`define MTE_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

// File: sv/mte_pkg.sv
// Types and constants of the MIDI track event encoder
`default_nettype none

package mte_pkg;

  typedef enum logic [2:0] {
    MODE_NOTE_OFF,
    MODE_NOTE_ON,
    MODE_POLY_PRESSURE,
    MODE_CONTROL,
    MODE_PROGRAM,
    MODE_CHAN_PRESSURE,
    MODE_BEND,
    MODE_END_TRACK
  } mode_t;

  typedef struct packed {
    mode_t        mode;
    logic [3:0]   channel;
    logic [6:0]   data1;
    logic [6:0]   data2;
    logic [13:0]  bend_value;
    logic [31:0]  stamp_seconds;
    logic [19:0]  stamp_micros;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
  } out_item_t;

  // event fields that travel alongside the tick math
  typedef struct packed {
    mode_t        mode;
    logic [3:0]   channel;
    logic [6:0]   data1;
    logic [6:0]   data2;
    logic [13:0]  bend_value;
  } evt_hdr_t;

  typedef struct packed {
    evt_hdr_t     hdr;
    logic [27:0]  delta;
  } evt_t;

  localparam logic [19:0] TPS_RESET      = 20'd192;
  localparam logic [20:0] MICROS_PER_SEC = 21'd1000000;
  // 1e6 = 64 * 15625; quotient by 15625 via reciprocal floor(2^40 / 15625)
  localparam logic [13:0] DIV_ODD        = 14'd15625;
  localparam logic [26:0] DIV_RECIP      = 27'd70368744;

  localparam logic [7:0] ST_NOTE_OFF      = 8'h80;
  localparam logic [7:0] ST_NOTE_ON       = 8'h90;
  localparam logic [7:0] ST_POLY_PRESSURE = 8'ha0;
  localparam logic [7:0] ST_CONTROL       = 8'hb0;
  localparam logic [7:0] ST_PROGRAM       = 8'hc0;
  localparam logic [7:0] ST_CHAN_PRESSURE = 8'hd0;
  localparam logic [7:0] ST_BEND          = 8'he0;
  localparam logic [7:0] META_STATUS      = 8'hff;
  localparam logic [7:0] META_END_TRACK   = 8'h2f;
  localparam logic [7:0] VLQ_CONT         = 8'h80;

endpackage

`default_nettype wire

// File: sv/midi_track_event_encoder_core.sv
// An event passes tick stages a to g, then the byte buffer, before its first byte shows.
// Throughput: one byte per cycle while out_stall is low; an event has 3 to 7 bytes,
// sent by the byte serializer with no gap between events while the input keeps up.
// The tick math runs in a seven-stage pipeline, so later events queue up behind it.
// Reset (synchronous, rst_n low) empties the pipeline and serializer, forgets the time
// origin and tick history, and sets the time base to 192 ticks per second.
`default_nettype none

module midi_track_event_encoder_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire mte_pkg::in_item_t  in_item,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output mte_pkg::out_item_t      out_item,
  input  wire logic               cfg_wr_en,
  input  wire logic [19:0]        cfg_wr_data
);

  logic [19:0]   tps_r;
  logic          evt_valid, evt_ready;
  mte_pkg::evt_t evt;

  logic       buf_v_r;
  logic [7:0] buf_bytes_r [7];
  logic [2:0] buf_cnt_r, buf_idx_r;
  logic       out_xfer, is_last, load;

  logic [7:0] bytes_nxt [7];
  logic [2:0] cnt_nxt;
  logic [6:0] g3, g2, g1, g0;
  logic [7:0] dl [4];
  logic [7:0] eb [3];
  logic [2:0] dcnt, ecnt, eidx;

  mte_tick_pipe u_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .tps       (tps_r),
    .evt_valid (evt_valid),
    .evt_ready (evt_ready),
    .evt       (evt)
  );

  assign out_valid          = buf_v_r;
  assign is_last            = (buf_idx_r == (buf_cnt_r - 3'd1));
  assign out_item.out_byte  = buf_bytes_r[buf_idx_r];
  assign out_item.last_byte = is_last;
  assign out_xfer           = buf_v_r && !out_stall;
  // next event loads as the last byte of the current one transfers
  assign evt_ready          = !buf_v_r || (out_xfer && is_last);
  assign load               = evt_valid && evt_ready;

  assign g3 = evt.delta[27:21];
  assign g2 = evt.delta[20:14];
  assign g1 = evt.delta[13:7];
  assign g0 = evt.delta[6:0];

  always_comb begin
    dl[0] = 8'h00;
    dl[1] = 8'h00;
    dl[2] = 8'h00;
    dl[3] = 8'h00;
    // leading zero groups are skipped, the final group always goes out
    if (g3 != 7'd0) begin
      dl[0] = mte_pkg::VLQ_CONT | {1'b0, g3};
      dl[1] = mte_pkg::VLQ_CONT | {1'b0, g2};
      dl[2] = mte_pkg::VLQ_CONT | {1'b0, g1};
      dl[3] = {1'b0, g0};
      dcnt  = 3'd4;
    end else if (g2 != 7'd0) begin
      dl[0] = mte_pkg::VLQ_CONT | {1'b0, g2};
      dl[1] = mte_pkg::VLQ_CONT | {1'b0, g1};
      dl[2] = {1'b0, g0};
      dcnt  = 3'd3;
    end else if (g1 != 7'd0) begin
      dl[0] = mte_pkg::VLQ_CONT | {1'b0, g1};
      dl[1] = {1'b0, g0};
      dcnt  = 3'd2;
    end else begin
      dl[0] = {1'b0, g0};
      dcnt  = 3'd1;
    end
  end

  always_comb begin
    eb[1] = {1'b0, evt.hdr.data1};
    eb[2] = {1'b0, evt.hdr.data2};
    ecnt  = 3'd3;
    case (evt.hdr.mode)
      mte_pkg::MODE_NOTE_OFF:      eb[0] = mte_pkg::ST_NOTE_OFF | {4'd0, evt.hdr.channel};
      mte_pkg::MODE_NOTE_ON:       eb[0] = mte_pkg::ST_NOTE_ON | {4'd0, evt.hdr.channel};
      mte_pkg::MODE_POLY_PRESSURE: eb[0] = mte_pkg::ST_POLY_PRESSURE | {4'd0, evt.hdr.channel};
      mte_pkg::MODE_CONTROL:       eb[0] = mte_pkg::ST_CONTROL | {4'd0, evt.hdr.channel};
      mte_pkg::MODE_PROGRAM: begin
        eb[0] = mte_pkg::ST_PROGRAM | {4'd0, evt.hdr.channel};
        ecnt  = 3'd2;
      end
      mte_pkg::MODE_CHAN_PRESSURE: begin
        eb[0] = mte_pkg::ST_CHAN_PRESSURE | {4'd0, evt.hdr.channel};
        eb[1] = {1'b0, evt.hdr.data2};
        ecnt  = 3'd2;
      end
      mte_pkg::MODE_BEND: begin
        eb[0] = mte_pkg::ST_BEND | {4'd0, evt.hdr.channel};
        eb[1] = {1'b0, evt.hdr.bend_value[6:0]};
        eb[2] = {1'b0, evt.hdr.bend_value[13:7]};
      end
      default: eb[0] = mte_pkg::ST_BEND | {4'd0, evt.hdr.channel};
    endcase
  end

  always_comb begin
    eidx = 3'd0;
    if (evt.hdr.mode == mte_pkg::MODE_END_TRACK) begin
      for (int i = 0; i < 7; i++) bytes_nxt[i] = 8'h00;
      bytes_nxt[1] = mte_pkg::META_STATUS;
      bytes_nxt[2] = mte_pkg::META_END_TRACK;
      cnt_nxt      = 3'd4;
    end else begin
      for (int i = 0; i < 7; i++) begin
        eidx = 3'(i) - dcnt;
        if (3'(i) < dcnt) begin
          bytes_nxt[i] = dl[2'(i)];
        end else begin
          case (eidx)
            3'd0:    bytes_nxt[i] = eb[0];
            3'd1:    bytes_nxt[i] = eb[1];
            default: bytes_nxt[i] = eb[2];
          endcase
        end
      end
      cnt_nxt = dcnt + ecnt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r     <= mte_pkg::TPS_RESET;
      buf_v_r   <= 1'b0;
      buf_idx_r <= 3'd0;
    end else begin
      if (cfg_wr_en) tps_r <= cfg_wr_data;
      if (load) begin
        buf_v_r   <= 1'b1;
        buf_idx_r <= 3'd0;
      end else if (out_xfer) begin
        if (is_last) buf_v_r <= 1'b0;
        else         buf_idx_r <= buf_idx_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      buf_cnt_r <= cnt_nxt;
      for (int i = 0; i < 7; i++) buf_bytes_r[i] <= bytes_nxt[i];
    end
  end

endmodule

`default_nettype wire

// File: sv/mte_tick_pipe.sv
// Stamp-to-tick pipeline: start capture, elapsed time, scaling, delta ticks
`default_nettype none

module mte_tick_pipe (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire mte_pkg::in_item_t in_item,
  input  wire logic [19:0]       tps,
  output logic                   evt_valid,
  input  wire logic              evt_ready,
  output mte_pkg::evt_t          evt
);

  logic a_v_r, b_v_r, c_v_r, d_v_r, e_v_r, f_v_r, g_v_r;
  logic a_rdy, b_rdy, c_rdy, d_rdy, e_rdy, f_rdy, g_rdy;
  logic in_xfer;

  logic        started_r;
  logic [31:0] start_sec_r;
  logic [19:0] start_us_r;
  logic [27:0] prev_r;

  mte_pkg::evt_hdr_t a_hdr_r, b_hdr_r, c_hdr_r, d_hdr_r, e_hdr_r, f_hdr_r;
  logic [31:0] a_sec_r;
  logic [19:0] a_us_r;

  logic [27:0] b_esec_r, c_esec_r, d_esec_r;
  logic        b_neg_r, c_neg_r, d_neg_r, e_neg_r, f_neg_r;
  logic [19:0] b_mag_r;
  logic [39:0] c_prod_r;
  logic [33:0] d_m_r, e_m_r;
  logic [43:0] d_pph_r, d_ppl_r;
  logic [20:0] e_q0_r, f_q_r;
  logic [27:0] e_sect_r, f_sect_r;
  mte_pkg::evt_t g_evt_r;

  logic [20:0] us_diff, us_adj;
  logic        borrow;
  logic [27:0] esec_nxt;
  logic [19:0] mag_nxt;
  logic [39:0] prod_nxt;
  logic [33:0] m_nxt;
  logic [43:0] pph_nxt, ppl_nxt;
  logic [60:0] recip_sum;
  logic [47:0] sec_prod;
  logic [34:0] back_prod;
  logic [15:0] rem;
  logic [20:0] q_nxt;
  logic [27:0] micro, ticks;

  assign g_rdy    = !g_v_r || evt_ready;
  assign f_rdy    = !f_v_r || g_rdy;
  assign e_rdy    = !e_v_r || f_rdy;
  assign d_rdy    = !d_v_r || e_rdy;
  assign c_rdy    = !c_v_r || d_rdy;
  assign b_rdy    = !b_v_r || c_rdy;
  assign a_rdy    = !a_v_r || b_rdy;
  assign in_stall = !a_rdy;
  assign in_xfer  = in_valid && a_rdy;

  assign evt_valid = g_v_r;
  assign evt       = g_evt_r;

  // elapsed seconds and micros, one borrow at most
  always_comb begin
    us_diff  = {1'b0, a_us_r} - {1'b0, start_us_r};
    borrow   = us_diff[20];
    us_adj   = borrow ? (us_diff + mte_pkg::MICROS_PER_SEC) : us_diff;
    mag_nxt  = us_adj[20] ? 20'(21'd0 - us_adj) : us_adj[19:0];
    esec_nxt = a_sec_r[27:0] - start_sec_r[27:0] - {27'd0, borrow};
  end

  assign prod_nxt = {20'd0, tps} * {20'd0, b_mag_r};

  // floor(prod / 64) / 15625 through the reciprocal, split in halves
  assign m_nxt   = c_prod_r[39:6];
  assign pph_nxt = {27'd0, m_nxt[33:17]} * {17'd0, mte_pkg::DIV_RECIP};
  assign ppl_nxt = {27'd0, m_nxt[16:0]} * {17'd0, mte_pkg::DIV_RECIP};

  assign recip_sum = {d_pph_r, 17'd0} + {17'd0, d_ppl_r};
  assign sec_prod  = {20'd0, d_esec_r} * {28'd0, tps};

  // estimate is low by at most one
  assign back_prod = {14'd0, e_q0_r} * {21'd0, mte_pkg::DIV_ODD};
  assign rem       = e_m_r[15:0] - back_prod[15:0];
  assign q_nxt     = (rem >= {2'd0, mte_pkg::DIV_ODD}) ? (e_q0_r + 21'd1) : e_q0_r;

  // micro term truncates toward zero, so a negative difference negates the quotient
  assign micro = f_neg_r ? (28'd0 - {7'd0, f_q_r}) : {7'd0, f_q_r};
  assign ticks = f_sect_r + micro;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r       <= 1'b0;
      b_v_r       <= 1'b0;
      c_v_r       <= 1'b0;
      d_v_r       <= 1'b0;
      e_v_r       <= 1'b0;
      f_v_r       <= 1'b0;
      g_v_r       <= 1'b0;
      started_r   <= 1'b0;
      start_sec_r <= 32'd0;
      start_us_r  <= 20'd0;
      prev_r      <= 28'd0;
    end else begin
      if (a_rdy) a_v_r <= in_valid;
      if (b_rdy) b_v_r <= a_v_r;
      if (c_rdy) c_v_r <= b_v_r;
      if (d_rdy) d_v_r <= c_v_r;
      if (e_rdy) e_v_r <= d_v_r;
      if (f_rdy) f_v_r <= e_v_r;
      if (g_rdy) g_v_r <= f_v_r;
      // first timed event fixes the time origin as it is taken in
      if (in_xfer && !started_r && in_item.mode != mte_pkg::MODE_END_TRACK) begin
        started_r   <= 1'b1;
        start_sec_r <= in_item.stamp_seconds;
        start_us_r  <= in_item.stamp_micros;
      end
      if (g_rdy && f_v_r && f_hdr_r.mode != mte_pkg::MODE_END_TRACK) begin
        prev_r <= ticks;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_rdy) begin
      a_hdr_r.mode       <= in_item.mode;
      a_hdr_r.channel    <= in_item.channel;
      a_hdr_r.data1      <= in_item.data1;
      a_hdr_r.data2      <= in_item.data2;
      a_hdr_r.bend_value <= in_item.bend_value;
      a_sec_r            <= in_item.stamp_seconds;
      a_us_r             <= in_item.stamp_micros;
    end
    if (b_rdy) begin
      b_hdr_r  <= a_hdr_r;
      b_esec_r <= esec_nxt;
      b_neg_r  <= us_adj[20];
      b_mag_r  <= mag_nxt;
    end
    if (c_rdy) begin
      c_hdr_r  <= b_hdr_r;
      c_esec_r <= b_esec_r;
      c_neg_r  <= b_neg_r;
      c_prod_r <= prod_nxt;
    end
    if (d_rdy) begin
      d_hdr_r  <= c_hdr_r;
      d_esec_r <= c_esec_r;
      d_neg_r  <= c_neg_r;
      d_m_r    <= m_nxt;
      d_pph_r  <= pph_nxt;
      d_ppl_r  <= ppl_nxt;
    end
    if (e_rdy) begin
      e_hdr_r  <= d_hdr_r;
      e_neg_r  <= d_neg_r;
      e_m_r    <= d_m_r;
      e_q0_r   <= recip_sum[60:40];
      e_sect_r <= sec_prod[27:0];
    end
    if (f_rdy) begin
      f_hdr_r  <= e_hdr_r;
      f_neg_r  <= e_neg_r;
      f_q_r    <= q_nxt;
      f_sect_r <= e_sect_r;
    end
    if (g_rdy) begin
      g_evt_r.hdr   <= f_hdr_r;
      g_evt_r.delta <= ticks - prev_r;
    end
  end

endmodule

`default_nettype wire

// File: sv/mte_checker.sv
// Port-level checks for the MIDI track event encoder, bound to the top level
`default_nettype none
`include "midi_track_event_encoder_core_assert.svh"

module mte_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire mte_pkg::in_item_t  in_item,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire mte_pkg::out_item_t out_item
);

  `MTE_ASSERT_RST(a_in_hold, in_valid && in_stall |=> in_valid && $stable(in_item), "stalled input changed")
  `MTE_ASSERT_RST(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_item), "stalled byte changed")
  // an event never ends mid-way: a byte that is not last is followed by another
  `MTE_ASSERT_RST(a_evt_cont, out_valid && !out_stall && !out_item.last_byte |=> out_valid, "event cut short")
  `MTE_ASSERT(a_rst_empty, !rst_n |=> !out_valid, "output not empty after reset")
  `MTE_ASSERT(a_rst_ready, !rst_n |=> !in_stall, "input stalled after reset")

endmodule

bind midi_track_event_encoder_core mte_checker u_mte_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .in_item     (in_item),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_item    (out_item)
);

`default_nettype wire

// File: tb/sv/tb_midi_track_event_encoder_core.sv
// Self-checking testbench for the MIDI track event encoder core
`default_nettype none

module tb_midi_track_event_encoder_core;
  import mte_pkg::*;

  localparam int HOLD_CYCLES = 300;   // long receiver hold-off, fills the pipeline
  localparam int SETTLE      = 16;    // extra wait after the expected bytes have all arrived
  localparam int IDLE_LIMIT  = 4000;  // cycles without any transfer before giving up
  localparam int PHASE_ITEMS = 76;

  // Tracks time origin and tick history, and keeps the bytes the core owes us.
  class track_byte_scoreboard;
    logic [19:0] rate;
    bit          started;
    logic [31:0] origin_sec;
    logic [19:0] origin_us;
    logic [31:0] last_ticks;
    out_item_t   expected_bytes[$];
    int          errors;

    function new();
      rate       = TPS_RESET;
      started    = 1'b0;
      origin_sec = '0;
      origin_us  = '0;
      last_ticks = '0;
      errors     = 0;
    endfunction

    function void set_rate(logic [19:0] v);
      rate = v;
    endfunction

    function void push_byte(logic [7:0] b, bit is_last);
      out_item_t e;
      e.out_byte  = b;
      e.last_byte = is_last;
      expected_bytes.push_back(e);
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction

    function void encode_event(in_item_t it);
      logic [31:0] esec;
      longint      eusec;
      longint      micro_term;
      longint      us_per_sec;
      logic [63:0] total;
      logic [31:0] ticks;
      logic [27:0] delta;
      logic [6:0]  grp;
      logic [7:0]  status;
      bit          leading;
      int          g;

      if (it.mode == MODE_END_TRACK) begin
        // meta event; stamp ignored, history untouched
        push_byte(8'h00, 1'b0);
        push_byte(META_STATUS, 1'b0);
        push_byte(META_END_TRACK, 1'b0);
        push_byte(8'h00, 1'b1);
        return;
      end

      if (!started) begin
        started    = 1'b1;
        origin_sec = it.stamp_seconds;
        origin_us  = it.stamp_micros;
        last_ticks = '0;
      end

      us_per_sec = MICROS_PER_SEC;
      esec  = it.stamp_seconds - origin_sec;
      eusec = longint'(it.stamp_micros) - longint'(origin_us);
      if (eusec < 0) begin
        eusec += us_per_sec;
        esec  -= 32'd1;
      end
      // can still be negative when the origin micros were out of range
      micro_term = (longint'(rate) * eusec) / us_per_sec;
      total = {32'd0, esec} * {44'd0, rate} + 64'(micro_term);
      ticks = total[31:0];
      delta = 28'(ticks - last_ticks);
      last_ticks = ticks;

      leading = 1'b0;
      for (g = 3; g >= 1; g--) begin
        grp = 7'(delta >> (7 * g));
        if (leading || grp != 0) begin
          leading = 1'b1;
          push_byte(VLQ_CONT | {1'b0, grp}, 1'b0);
        end
      end
      push_byte({1'b0, delta[6:0]}, 1'b0);

      case (it.mode)
        MODE_NOTE_OFF:      status = ST_NOTE_OFF;
        MODE_NOTE_ON:       status = ST_NOTE_ON;
        MODE_POLY_PRESSURE: status = ST_POLY_PRESSURE;
        MODE_CONTROL:       status = ST_CONTROL;
        MODE_PROGRAM:       status = ST_PROGRAM;
        MODE_CHAN_PRESSURE: status = ST_CHAN_PRESSURE;
        default:            status = ST_BEND;
      endcase
      push_byte(status | {4'h0, it.channel}, 1'b0);

      case (it.mode)
        MODE_PROGRAM:       push_byte({1'b0, it.data1}, 1'b1);
        MODE_CHAN_PRESSURE: push_byte({1'b0, it.data2}, 1'b1);
        MODE_BEND: begin
          push_byte({1'b0, it.bend_value[6:0]}, 1'b0);
          push_byte({1'b0, it.bend_value[13:7]}, 1'b1);
        end
        default: begin
          push_byte({1'b0, it.data1}, 1'b0);
          push_byte({1'b0, it.data2}, 1'b1);
        end
      endcase
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("mismatch: %s", msg);
    endtask

    task check_byte(out_item_t got);
      out_item_t want;
      if (expected_bytes.size() == 0) begin
        report($sformatf("unexpected byte %02h last=%0b", got.out_byte, got.last_byte));
        return;
      end
      want = expected_bytes.pop_front();
      if (got.out_byte !== want.out_byte)
        report($sformatf("out_byte %02h, want %02h", got.out_byte, want.out_byte));
      if (got.last_byte !== want.last_byte)
        report($sformatf("last_byte %0b on %02h, want %0b", got.last_byte, got.out_byte,
                         want.last_byte));
    endtask
  endclass

  logic        clk;
  logic        rst_n       = 1'b0;
  logic        in_valid    = 1'b0;
  logic        in_stall;
  in_item_t    in_item     = '0;
  logic        out_valid;
  logic        out_stall   = 1'b0;
  out_item_t   out_item;
  logic        cfg_wr_en   = 1'b0;
  logic [19:0] cfg_wr_data = '0;

  track_byte_scoreboard sb;
  bit          hold_req = 1'b0;
  bit          quiet    = 1'b0;
  logic [31:0] cur_sec;
  logic [19:0] cur_us;
  int          idle_cycles = 0;

  midi_track_event_encoder_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // mostly none or short, now and then a long one
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic in_item_t make_event(mode_t m, logic [3:0] ch, logic [6:0] d1,
                                          logic [6:0] d2, logic [13:0] bend,
                                          logic [31:0] sec, logic [19:0] us);
    in_item_t it;
    it.mode          = m;
    it.channel       = ch;
    it.data1         = d1;
    it.data2         = d2;
    it.bend_value    = bend;
    it.stamp_seconds = sec;
    it.stamp_micros  = us;
    return it;
  endfunction

  // Mostly a forward-running track with random content; some stamps are pure noise.
  function automatic in_item_t random_event();
    mode_t       m;
    int          r;
    logic [31:0] sec;
    logic [19:0] us;
    m = ($urandom_range(0, 99) < 6) ? MODE_END_TRACK : mode_t'($urandom_range(0, 6));
    r = $urandom_range(0, 99);
    if (r < 10) begin
      sec = $urandom;
      us  = 20'($urandom_range(0, 20'hFFFFF));
    end else begin
      if (r >= 15) begin
        if (r < 80) cur_sec += $urandom_range(0, 2);
        else if (r < 95) cur_sec += $urandom_range(3, 60);
        else cur_sec += $urandom_range(200, 600);
        cur_us = ($urandom_range(0, 9) == 0) ? 20'($urandom_range(1000000, 20'hFFFFF))
                                             : 20'($urandom_range(0, 999999));
      end
      sec = cur_sec;
      us  = cur_us;
    end
    return make_event(m, 4'($urandom), 7'($urandom), 7'($urandom), 14'($urandom), sec, us);
  endfunction

  task automatic send_event(input in_item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain_and_pause();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_rate(input logic [19:0] v);
    cfg_wr_data <= v;
    cfg_wr_en   <= 1'b1;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // receiver side: random stalls, plus one long hold-off on request
  initial begin
    int n;
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        n = pick_gap();
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  // transfer monitor and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_wr_en) sb.set_rate(cfg_wr_data);
      if (in_valid && !in_stall) sb.encode_event(in_item);
      if (out_valid && !out_stall) sb.check_byte(out_item);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
          $display("*** FAILED ***");
          $finish;
        end
      end
    end
  end

  initial begin
    logic [19:0] rates[5];
    sb = new();
    rates[0] = 20'hFFFFF;
    rates[1] = 20'd1;
    rates[2] = 20'd0;
    rates[3] = 20'($urandom_range(2, 20'hFFFFE));
    rates[4] = TPS_RESET;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part at the reset time base
    // end of track before any timed event leaves the origin unset
    send_event(make_event(MODE_END_TRACK, 4'h3, 7'h00, 7'h00, 14'h0, 32'h12345678, 20'd7));
    // origin taken with out-of-range micros so a negative micro term is reachable
    send_event(make_event(MODE_NOTE_ON, 4'h0, 7'h00, 7'h00, 14'h0, 32'd100, 20'hFFFFF));
    send_event(make_event(MODE_NOTE_ON, 4'h0, 7'h00, 7'h00, 14'h0, 32'd100, 20'hFFFFF));
    // borrow still negative: micro term below zero, ticks wrap
    send_event(make_event(MODE_NOTE_OFF, 4'hF, 7'h7F, 7'h7F, 14'h0, 32'd101, 20'd0));
    send_event(make_event(MODE_POLY_PRESSURE, 4'h5, 7'h2A, 7'h55, 14'h0, 32'd101, 20'hFFFFF));
    send_event(make_event(MODE_CONTROL, 4'hA, 7'h40, 7'h01, 14'h0, 32'd102, 20'd500000));
    // stamp before the origin
    send_event(make_event(MODE_PROGRAM, 4'hF, 7'h7F, 7'h00, 14'h0, 32'd50, 20'd999999));
    send_event(make_event(MODE_CHAN_PRESSURE, 4'h0, 7'h00, 7'h7F, 14'h0, 32'hFFFFFFFF,
                          20'd999999));
    send_event(make_event(MODE_BEND, 4'h7, 7'h00, 7'h00, 14'h3FFF, 32'd0, 20'd0));
    send_event(make_event(MODE_BEND, 4'h8, 7'h7F, 7'h7F, 14'h0000, 32'd103, 20'd1));
    send_event(make_event(MODE_BEND, 4'h1, 7'h00, 7'h00, 14'h2AAA, 32'd104, 20'd250000));
    send_event(make_event(MODE_BEND, 4'hE, 7'h00, 7'h00, 14'h1555, 32'd104, 20'd250000));
    send_event(make_event(MODE_CONTROL, 4'h2, 7'h07, 7'h64, 14'h0, 32'd105, 20'hFFFFF));
    send_event(make_event(MODE_END_TRACK, 4'hF, 7'h7F, 7'h7F, 14'h3FFF, 32'hFFFFFFFF,
                          20'hFFFFF));
    send_event(make_event(MODE_NOTE_ON, 4'h9, 7'h3C, 7'h40, 14'h0, 32'd108, 20'd10));

    cur_sec = 32'd110;
    cur_us  = 20'd0;
    for (int p = 0; p < 5; p++) begin
      drain_and_pause();
      write_rate(rates[p]);
      if (p == 0) hold_req = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        quiet = (p == 3 && i < 30);
        send_event(random_event());
      end
      quiet = 1'b0;
    end

    drain_and_pause();
    if (sb.pending() != 0) sb.report($sformatf("%0d bytes never arrived", sb.pending()));
    if (sb.errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

`default_nettype wire
